// File: hw/rtl/sswt_pkg.sv
// ----------------------------------------------------------------------------
// sswt_pkg: shared types and constants for the slow-start window throttle
// Field widths, register indexes, reset values, controller states and the
// command/status groups that link the controller to the datapath.
// ----------------------------------------------------------------------------
package sswt_pkg;

   localparam int TIMEOUT_W  = 16;
   localparam int WIN_INT_W  = 12;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int PENDING_W  = 12;
   localparam int WINDOW_Q_W = 28;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT      = 16'd5000;
   localparam logic [WIN_INT_W-1:0] RESET_MAX_WINDOW   = 12'd400;
   localparam logic [WIN_INT_W-1:0] RESET_INIT_WINDOW  = 12'd1;
   localparam logic [WIN_INT_W-1:0] RESET_INIT_THRESH  = 12'd2;
   localparam logic [WIN_INT_W-1:0] THRESH_FLOOR       = 12'd2;
   localparam logic [PENDING_W-1:0] PENDING_MAX        = 12'd4095;

   localparam logic ACTION_ISSUE  = 1'b0;
   localparam logic ACTION_RETURN = 1'b1;

   typedef enum logic [1:0] {
      CSR_TIMEOUT     = 2'd0,
      CSR_MAX_WINDOW  = 2'd1,
      CSR_INIT_WINDOW = 2'd2,
      CSR_INIT_THRESH = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic take_item;
      logic eval;
      logic div_start;
      logic div_commit;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_divide;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// File: hw/rtl/sswt_recip.sv
// ----------------------------------------------------------------------------
// sswt_recip: serial reciprocal unit
// Restoring division of 2^(2*FRACTION_BITS) by the window, one quotient bit
// per cycle; done pulses for one cycle once the quotient is final.
// ----------------------------------------------------------------------------
module sswt_recip #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [12+FRACTION_BITS-1:0]      divisor,
   output logic                             done,
   output logic [2*FRACTION_BITS:0]         quotient
);
   import sswt_pkg::*;

   localparam int WIN_W  = WIN_INT_W + FRACTION_BITS;
   localparam int QUO_W  = 2 * FRACTION_BITS + 1;
   localparam int STEP_W = $clog2(QUO_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WIN_W-1:0]  div_ff, div_in;
   logic [WIN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [WIN_W:0]    partial;
   logic [WIN_W:0]    diff;
   logic              qbit;

   always_comb begin
      // dividend is a single one followed by zeros
      partial = {rem_ff, (step_ff == '0)};
      diff    = partial - {1'b0, div_ff};
      qbit    = (partial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[WIN_W-1:0] : partial[WIN_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/sswt_dp.sv
// ----------------------------------------------------------------------------
// sswt_dp: throttle datapath
// Control registers, window/limit/pending/counter state, event evaluation,
// reciprocal growth and the result register.
// ----------------------------------------------------------------------------
module sswt_dp #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sswt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sswt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sswt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   input  logic                                  req_action,
   input  logic [sswt_pkg::TIME_W-1:0]           req_now_ms,
   input  logic [sswt_pkg::TIME_W-1:0]           req_sent_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_granted,
   output logic                                  rsp_on_time,
   output logic [sswt_pkg::WINDOW_Q_W-1:0]       rsp_window_q,
   output logic [sswt_pkg::PENDING_W-1:0]        rsp_pending_now,
   output logic [sswt_pkg::COUNT_W-1:0]          rsp_ok_total,
   output logic [sswt_pkg::COUNT_W-1:0]          rsp_late_total,
   input  sswt_pkg::ctrl_cmd_type                cmd,
   output sswt_pkg::dp_status_type               status
);
   import sswt_pkg::*;

   localparam int WIN_W = WIN_INT_W + FRACTION_BITS;
   localparam int QUO_W = 2 * FRACTION_BITS + 1;
   localparam int SUM_W = ((WIN_W > QUO_W) ? WIN_W : QUO_W) + 1;
   localparam logic [WIN_W-1:0] ONE_Q   = WIN_W'(1) << FRACTION_BITS;
   localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};
   localparam logic [WIN_W-1:0] WINDOW_RESET =
      {RESET_INIT_WINDOW, {FRACTION_BITS{1'b0}}};

   // control registers
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [WIN_INT_W-1:0] max_win_ff, max_win_in;
   logic [WIN_INT_W-1:0] init_win_ff, init_win_in;
   logic [WIN_INT_W-1:0] init_thr_ff, init_thr_in;

   // throttle state
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [WIN_INT_W-1:0] limit_ff, limit_in;
   logic [TIME_W-1:0]    last_fail_ff, last_fail_in;
   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic [COUNT_W-1:0]   ok_ff, ok_in;
   logic [COUNT_W-1:0]   late_ff, late_in;

   // latched input beat and event flags
   logic                 action_ff, action_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    sent_ff, sent_in;
   logic                 grant_ff, grant_in;
   logic                 on_time_ff, on_time_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_grant_ff, out_grant_in;
   logic                  out_on_time_ff, out_on_time_in;
   logic [WINDOW_Q_W-1:0] out_window_ff, out_window_in;
   logic [PENDING_W-1:0]  out_pending_ff, out_pending_in;
   logic [COUNT_W-1:0]    out_ok_ff, out_ok_in;
   logic [COUNT_W-1:0]    out_late_ff, out_late_in;

   logic                        csr_wr;
   csr_index_type               csr_index;
   logic signed [TIME_W:0]      lat;
   logic signed [TIME_W+1:0]    lat_x2;
   logic signed [TIMEOUT_W:0]   to_s;
   logic                        is_on_time;
   logic                        is_fast;
   logic                        below_max;
   logic                        above_limit;
   logic                        can_grant;
   logic [WIN_W:0]              sum_one;
   logic [SUM_W-1:0]            sum_recip;
   logic [WIN_INT_W-1:0]        half;
   logic                        div_done;
   logic [QUO_W-1:0]            recip;

   sswt_recip #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (window_ff),
      .done     (div_done),
      .quotient (recip)
   );

   assign csr_wr    = csr_psel & csr_penable & csr_pwrite;
   assign csr_index = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         CSR_TIMEOUT:     csr_prdata = CSR_DATA_W'(timeout_ff);
         CSR_MAX_WINDOW:  csr_prdata = CSR_DATA_W'(max_win_ff);
         CSR_INIT_WINDOW: csr_prdata = CSR_DATA_W'(init_win_ff);
         CSR_INIT_THRESH: csr_prdata = CSR_DATA_W'(init_thr_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // event evaluation terms
   always_comb begin
      lat         = $signed({1'b0, now_ff}) - $signed({1'b0, sent_ff});
      lat_x2      = $signed({lat, 1'b0});
      to_s        = $signed({1'b0, timeout_ff});
      is_on_time  = (lat < to_s);
      is_fast     = (lat_x2 < to_s);
      below_max   = (window_ff < {max_win_ff, {FRACTION_BITS{1'b0}}});
      above_limit = (window_ff > {limit_ff, {FRACTION_BITS{1'b0}}});
      can_grant   = (pending_ff != PENDING_MAX) &&
                    ({pending_ff, {FRACTION_BITS{1'b0}}} < window_ff);
      sum_one     = {1'b0, window_ff} + {1'b0, ONE_Q};
      sum_recip   = SUM_W'(window_ff) + SUM_W'(recip);
      half        = {1'b0, window_ff[WIN_W-1:FRACTION_BITS+1]};
   end

   always_comb begin
      status.need_divide = (action_ff == ACTION_RETURN) && is_fast &&
                           below_max && above_limit;
      status.div_done    = div_done;
      status.out_free    = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      timeout_in     = timeout_ff;
      max_win_in     = max_win_ff;
      init_win_in    = init_win_ff;
      init_thr_in    = init_thr_ff;
      window_in      = window_ff;
      limit_in       = limit_ff;
      last_fail_in   = last_fail_ff;
      pending_in     = pending_ff;
      ok_in          = ok_ff;
      late_in        = late_ff;
      action_in      = action_ff;
      now_in         = now_ff;
      sent_in        = sent_ff;
      grant_in       = grant_ff;
      on_time_in     = on_time_ff;
      out_valid_in   = out_valid_ff;
      out_grant_in   = out_grant_ff;
      out_on_time_in = out_on_time_ff;
      out_window_in  = out_window_ff;
      out_pending_in = out_pending_ff;
      out_ok_in      = out_ok_ff;
      out_late_in    = out_late_ff;

      if (csr_wr) begin
         unique case (csr_index)
            CSR_TIMEOUT:    timeout_in = csr_pwdata[TIMEOUT_W-1:0];
            CSR_MAX_WINDOW: max_win_in = csr_pwdata[WIN_INT_W-1:0];
            CSR_INIT_WINDOW: begin
               init_win_in = csr_pwdata[WIN_INT_W-1:0];
               window_in   = {csr_pwdata[WIN_INT_W-1:0], {FRACTION_BITS{1'b0}}};
            end
            CSR_INIT_THRESH: begin
               init_thr_in = csr_pwdata[WIN_INT_W-1:0];
               limit_in    = csr_pwdata[WIN_INT_W-1:0];
            end
            default: ;
         endcase
      end

      if (cmd.take_item) begin
         action_in = req_action;
         now_in    = req_now_ms;
         sent_in   = req_sent_ms;
      end

      if (cmd.eval) begin
         grant_in   = 1'b0;
         on_time_in = 1'b0;
         if (action_ff == ACTION_ISSUE) begin
            if (can_grant) begin
               pending_in = pending_ff + 1'b1;
               grant_in   = 1'b1;
            end
         end else begin
            if (pending_ff != '0) begin
               pending_in = pending_ff - 1'b1;
            end
            if (is_on_time) begin
               ok_in      = ok_ff + 1'b1;
               on_time_in = 1'b1;
            end else begin
               late_in = late_ff + 1'b1;
            end
            if (is_fast) begin
               // growth above the limit waits for the reciprocal unit
               if (below_max && !above_limit) begin
                  window_in = sum_one[WIN_W] ? WIN_MAX : sum_one[WIN_W-1:0];
               end
            end else if (sent_ff > last_fail_ff) begin
               limit_in     = (half > THRESH_FLOOR) ? half : THRESH_FLOOR;
               window_in    = ONE_Q;
               last_fail_in = now_ff;
            end
         end
      end

      if (cmd.div_commit) begin
         window_in = (sum_recip[SUM_W-1:WIN_W] != '0) ? WIN_MAX
                                                      : sum_recip[WIN_W-1:0];
      end

      if (cmd.publish) begin
         out_valid_in   = 1'b1;
         out_grant_in   = grant_ff;
         out_on_time_in = on_time_ff;
         out_window_in  = WINDOW_Q_W'(window_ff);
         out_pending_in = pending_ff;
         out_ok_in      = ok_ff;
         out_late_in    = late_ff;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= RESET_TIMEOUT;
         max_win_ff   <= RESET_MAX_WINDOW;
         init_win_ff  <= RESET_INIT_WINDOW;
         init_thr_ff  <= RESET_INIT_THRESH;
         window_ff    <= WINDOW_RESET;
         limit_ff     <= RESET_INIT_THRESH;
         last_fail_ff <= '0;
         pending_ff   <= '0;
         ok_ff        <= '0;
         late_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         max_win_ff   <= max_win_in;
         init_win_ff  <= init_win_in;
         init_thr_ff  <= init_thr_in;
         window_ff    <= window_in;
         limit_ff     <= limit_in;
         last_fail_ff <= last_fail_in;
         pending_ff   <= pending_in;
         ok_ff        <= ok_in;
         late_ff      <= late_in;
         out_valid_ff <= out_valid_in;
      end
      action_ff      <= action_in;
      now_ff         <= now_in;
      sent_ff        <= sent_in;
      grant_ff       <= grant_in;
      on_time_ff     <= on_time_in;
      out_grant_ff   <= out_grant_in;
      out_on_time_ff <= out_on_time_in;
      out_window_ff  <= out_window_in;
      out_pending_ff <= out_pending_in;
      out_ok_ff      <= out_ok_in;
      out_late_ff    <= out_late_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_granted     = out_grant_ff;
   assign rsp_on_time     = out_on_time_ff;
   assign rsp_window_q    = out_window_ff;
   assign rsp_pending_now = out_pending_ff;
   assign rsp_ok_total    = out_ok_ff;
   assign rsp_late_total  = out_late_ff;

endmodule

// File: hw/rtl/sswt_ctrl.sv
// ----------------------------------------------------------------------------
// sswt_ctrl: throttle controller
// Sequences one event: take the beat, evaluate, optionally run the
// reciprocal unit, then load the result register.
// ----------------------------------------------------------------------------
module sswt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sswt_pkg::dp_status_type  status,
   output sswt_pkg::ctrl_cmd_type   cmd
);
   import sswt_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = status.need_divide ? ST_DIVIDE : ST_PUBLISH;
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.take_item = req_valid;
         end
         ST_EVAL: begin
            cmd.eval      = 1'b1;
            cmd.div_start = status.need_divide;
         end
         ST_DIVIDE: begin
            cmd.div_commit = status.div_done;
         end
         ST_PUBLISH: begin
            // hold until the previous result beat has left
            cmd.publish = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/slow_start_window_throttle_unit.sv
// ----------------------------------------------------------------------------
// slow_start_window_throttle_unit: slow-start outstanding-request throttle
// Sequence: the input beat is latched, evaluated, then loaded into the result
//   register; growth above the limit runs the reciprocal unit before that load.
// A new event is taken only after the last one is published; growth by 1/window
//   waits on the bit-serial reciprocal unit, and a stalled result holds req_stall.
// Reset: synchronous; registers load their defaults and no result is valid.
// ----------------------------------------------------------------------------
module slow_start_window_throttle_unit #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sswt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [sswt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [sswt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [sswt_pkg::TIME_W-1:0]           req_now_ms,
   input  logic [sswt_pkg::TIME_W-1:0]           req_sent_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_granted,
   output logic                                  rsp_on_time,
   output logic [sswt_pkg::WINDOW_Q_W-1:0]       rsp_window_q,
   output logic [sswt_pkg::PENDING_W-1:0]        rsp_pending_now,
   output logic [sswt_pkg::COUNT_W-1:0]          rsp_ok_total,
   output logic [sswt_pkg::COUNT_W-1:0]          rsp_late_total
);
   import sswt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;

   sswt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sswt_dp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .req_action      (req_action),
      .req_now_ms      (req_now_ms),
      .req_sent_ms     (req_sent_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_granted     (rsp_granted),
      .rsp_on_time     (rsp_on_time),
      .rsp_window_q    (rsp_window_q),
      .rsp_pending_now (rsp_pending_now),
      .rsp_ok_total    (rsp_ok_total),
      .rsp_late_total  (rsp_late_total),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// File: dv/tb_slow_start_window_throttle_unit.sv
// ----------------------------------------------------------------------------
// tb_slow_start_window_throttle_unit: self-checking bench for the throttle
// Drives issue and return events through the request channel, mirrors the
// congestion window, slow-start limit and counters in a local predictor, and
// compares every result beat field by field. Register profiles, including their
// extremes, are swept between phases, with random gaps on both channels and one
// long result stall that backs up the request side.
// ----------------------------------------------------------------------------
module tb_slow_start_window_throttle_unit;
   import sswt_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam longint unsigned WINDOW_SAT = (64'd1 << (WIN_INT_W + FRAC_BITS)) - 64'd1;
   localparam int HOLD_LONG = 300;
   localparam int DRAIN_CYCLES = 2 * FRAC_BITS + 12;

   typedef struct {
      logic                  granted;
      logic                  on_time;
      logic [WINDOW_Q_W-1:0] window_q;
      logic [PENDING_W-1:0]  pending_now;
      logic [COUNT_W-1:0]    ok_total;
      logic [COUNT_W-1:0]    late_total;
   } throttle_beat_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_action;
   logic [TIME_W-1:0]     req_now_ms;
   logic [TIME_W-1:0]     req_sent_ms;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_granted;
   logic                  rsp_on_time;
   logic [WINDOW_Q_W-1:0] rsp_window_q;
   logic [PENDING_W-1:0]  rsp_pending_now;
   logic [COUNT_W-1:0]    rsp_ok_total;
   logic [COUNT_W-1:0]    rsp_late_total;

   // predictor state
   logic [TIMEOUT_W-1:0] cfg_timeout;
   logic [WIN_INT_W-1:0] cfg_max_window;
   logic [WIN_INT_W-1:0] cfg_init_window;
   logic [WIN_INT_W-1:0] cfg_init_thresh;
   longint unsigned      win_q;
   longint unsigned      ss_limit;
   logic [TIME_W-1:0]    last_fail_ms;
   logic [PENDING_W-1:0] outstanding_cnt;
   logic [COUNT_W-1:0]   ok_cnt;
   logic [COUNT_W-1:0]   late_cnt;

   throttle_beat_type expected_beats[$];
   throttle_beat_type exp_beat;

   bit send_idle;
   bit rsp_idle;
   bit long_hold_req;
   int rsp_hold_left;
   int n_errors;
   int n_sent;
   int n_checked;
   int n_grants;
   int n_backoffs;
   int n_frac_steps;

   slow_start_window_throttle_unit #(
      .FRACTION_BITS(FRAC_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_now_ms     (req_now_ms),
      .req_sent_ms    (req_sent_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted    (rsp_granted),
      .rsp_on_time    (rsp_on_time),
      .rsp_window_q   (rsp_window_q),
      .rsp_pending_now(rsp_pending_now),
      .rsp_ok_total   (rsp_ok_total),
      .rsp_late_total (rsp_late_total)
   );

   always #2 clock = ~clock;

   initial begin
      #10000000;
      $display("Test completed with failures");
      $finish;
   end

   function void reset_throttle_model();
      cfg_timeout     = RESET_TIMEOUT;
      cfg_max_window  = RESET_MAX_WINDOW;
      cfg_init_window = RESET_INIT_WINDOW;
      cfg_init_thresh = RESET_INIT_THRESH;
      win_q           = {52'd0, RESET_INIT_WINDOW} << FRAC_BITS;
      ss_limit        = RESET_INIT_THRESH;
      last_fail_ms    = '0;
      outstanding_cnt = '0;
      ok_cnt          = '0;
      late_cnt        = '0;
   endfunction

   function void apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_TIMEOUT: begin
            cfg_timeout = value[TIMEOUT_W-1:0];
         end
         CSR_MAX_WINDOW: begin
            cfg_max_window = value[WIN_INT_W-1:0];
         end
         CSR_INIT_WINDOW: begin
            cfg_init_window = value[WIN_INT_W-1:0];
            win_q = {52'd0, value[WIN_INT_W-1:0]} << FRAC_BITS;
         end
         CSR_INIT_THRESH: begin
            cfg_init_thresh = value[WIN_INT_W-1:0];
            ss_limit = value[WIN_INT_W-1:0];
         end
         default: ;
      endcase
   endfunction

   // Apply one event to the mirrored window state and return the beat it yields.
   function automatic throttle_beat_type advance_throttle(logic action,
                                                          logic [TIME_W-1:0] now,
                                                          logic [TIME_W-1:0] sent);
      throttle_beat_type beat;
      longint          lat;
      longint          limit_ms;
      longint unsigned pend_q;
      longint unsigned cap_q;
      longint unsigned knee_q;
      longint unsigned half;
      longint unsigned recip;
      beat.granted = 1'b0;
      beat.on_time = 1'b0;
      pend_q = outstanding_cnt;
      if (action == ACTION_ISSUE) begin
         if (outstanding_cnt < PENDING_MAX && (pend_q << FRAC_BITS) < win_q) begin
            outstanding_cnt++;
            beat.granted = 1'b1;
            n_grants++;
         end
      end else begin
         lat      = longint'({32'd0, now}) - longint'({32'd0, sent});
         limit_ms = longint'({48'd0, cfg_timeout});
         cap_q    = cfg_max_window;
         cap_q    = cap_q << FRAC_BITS;
         knee_q   = ss_limit << FRAC_BITS;
         if (outstanding_cnt != 0)
            outstanding_cnt--;
         if (lat < limit_ms) begin
            ok_cnt++;
            beat.on_time = 1'b1;
         end else begin
            late_cnt++;
         end
         if (2 * lat < limit_ms) begin
            if (win_q < cap_q) begin
               // above the knee grow by the truncated reciprocal, else by one
               if (win_q > knee_q) begin
                  recip = (64'd1 << (2 * FRAC_BITS)) / win_q;
                  win_q = (win_q + recip > WINDOW_SAT) ? WINDOW_SAT : win_q + recip;
                  n_frac_steps++;
               end else begin
                  win_q = win_q + (64'd1 << FRAC_BITS);
                  if (win_q > WINDOW_SAT)
                     win_q = WINDOW_SAT;
               end
            end
         end else if (sent > last_fail_ms) begin
            half         = win_q >> (FRAC_BITS + 1);
            ss_limit     = (half > THRESH_FLOOR) ? half : THRESH_FLOOR;
            win_q        = 64'd1 << FRAC_BITS;
            last_fail_ms = now;
            n_backoffs++;
         end
      end
      beat.window_q    = win_q[WINDOW_Q_W-1:0];
      beat.pending_now = outstanding_cnt;
      beat.ok_total    = ok_cnt;
      beat.late_total  = late_cnt;
      return beat;
   endfunction

   function void check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (actv !== expv) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, expv, actv);
         n_errors++;
      end
   endfunction

   task automatic send_event(logic action, logic [TIME_W-1:0] now, logic [TIME_W-1:0] sent);
      int gap;
      gap = send_idle ? $urandom_range(0, 11) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_action  <= action;
      req_now_ms  <= now;
      req_sent_ms <= sent;
      do @(posedge clock); while (req_stall);
      expected_beats.insert(expected_beats.size(), advance_throttle(action, now, sent));
      n_sent++;
   endtask

   // Write a register, then read it back through the same port.
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_csr(idx, value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      check_field("register readback", value, readback);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_profile(int timeout_ms, int max_win, int init_win, int init_thresh);
      wait_drained();
      write_csr(CSR_TIMEOUT, timeout_ms);
      write_csr(CSR_MAX_WINDOW, max_win);
      write_csr(CSR_INIT_THRESH, init_thresh);
      write_csr(CSR_INIT_WINDOW, init_win);
   endtask

   // Mostly a running clock with latencies spread around the timeout.
   task automatic random_events(int count);
      logic [TIME_W-1:0] clk_ms;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] sent;
      logic              action;
      int                kind;
      int                half_to;
      clk_ms = $urandom;
      repeat (count) begin
         action  = ($urandom_range(0, 99) < 50) ? ACTION_ISSUE : ACTION_RETURN;
         clk_ms += $urandom_range(0, cfg_timeout / 4 + 8);
         now     = clk_ms;
         half_to = cfg_timeout / 2;
         kind    = $urandom_range(0, 19);
         if (kind < 9)
            sent = now - $urandom_range(0, half_to);
         else if (kind < 13)
            sent = now - $urandom_range(half_to, cfg_timeout);
         else if (kind < 17)
            sent = now - $urandom_range(cfg_timeout, 3 * cfg_timeout);
         else if (kind < 19)
            sent = now + $urandom_range(1, 5000);
         else begin
            now  = $urandom;
            sent = $urandom;
         end
         send_event(action, now, sent);
      end
   endtask

   task automatic test_directed_events();
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
      send_event(ACTION_ISSUE, 32'd0, 32'd0);
      send_event(ACTION_ISSUE, 32'd10, 32'hFFFF_FFFF);
      send_event(ACTION_RETURN, 32'd1000, 32'd900);
      // nothing outstanding
      send_event(ACTION_RETURN, 32'd1100, 32'd1000);
      send_event(ACTION_RETURN, 32'd1200, 32'd1150);
      // negative latency
      send_event(ACTION_RETURN, 32'd0, 32'hFFFF_FFFF);
      // twice the latency equals the timeout: on time but backs off
      send_event(ACTION_RETURN, 32'd4500, 32'd2000);
      // latency equals the timeout, sent before the last failure
      send_event(ACTION_RETURN, 32'd8000, 32'd3000);
      send_event(ACTION_RETURN, 32'hFFFF_FFFF, 32'd0);
      send_event(ACTION_RETURN, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_event(ACTION_RETURN, 32'h0000_0010, 32'hFFFF_FFF0);
      send_event(ACTION_RETURN, 32'h8000_1F40, 32'h8000_0000);
      send_event(ACTION_ISSUE, 32'h5555_5555, 32'hAAAA_AAAA);
      send_event(ACTION_ISSUE, 32'hAAAA_AAAA, 32'h5555_5555);
      send_event(ACTION_RETURN, 32'h8000_2000, 32'h8000_1F00);
      send_event(ACTION_ISSUE, 32'h8000_2001, 32'd0);
      wait_drained();
   endtask

   task automatic test_zero_window();
      write_csr(CSR_INIT_WINDOW, 0);
      send_event(ACTION_ISSUE, 32'd100, 32'd0);
      send_event(ACTION_RETURN, 32'd200, 32'd190);
      send_event(ACTION_ISSUE, 32'd300, 32'd0);
      send_event(ACTION_RETURN, 32'd400, 32'd395);
      wait_drained();
   endtask

   task automatic test_register_sweep();
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
      set_profile(5000, 400, 1, 2);
      random_events(250);
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      set_profile(1, 1, 1, 2);
      random_events(100);
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
      set_profile(65535, 4000, 4000, 4000);
      random_events(200);
      send_idle = 1'b1;
      rsp_idle  = 1'b0;
      set_profile($urandom_range(100, 3000), $urandom_range(8, 64), $urandom_range(1, 8),
                  $urandom_range(2, 16));
      random_events(300);
      send_idle = 1'b0;
      rsp_idle  = 1'b1;
      set_profile(200, 4000, 2, 4000);
      random_events(150);
      wait_drained();
   endtask

   task automatic test_result_backpressure();
      set_profile(600, 32, 4, 8);
      send_idle = 1'b0;
      rsp_idle  = 1'b1;
      @(posedge clock);
      long_hold_req = 1'b1;
      random_events(48);
      wait_drained();
   endtask

   // fill the window with issues until they are refused, then free one slot
   task automatic test_window_full();
      set_profile(5000, 64, 48, 2);
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      repeat (56)
         send_event(ACTION_ISSUE, $urandom, $urandom);
      send_event(ACTION_RETURN, 32'd50, 32'd49);
      send_event(ACTION_ISSUE, 32'd51, 32'd0);
      send_event(ACTION_ISSUE, 32'd52, 32'd0);
      wait_drained();
   endtask

   // result-side stall: short random holds per beat, or one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_hold_left = HOLD_LONG;
            long_hold_req = 1'b0;
         end
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         rsp_hold_left = rsp_idle ? $urandom_range(0, 11) : 0;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got window 0x%0h",
                     $time, rsp_window_q);
            n_errors++;
         end else begin
            exp_beat = expected_beats[0];
            expected_beats.delete(0);
            check_field("granted", exp_beat.granted, rsp_granted);
            check_field("on_time", exp_beat.on_time, rsp_on_time);
            check_field("window_q", exp_beat.window_q, rsp_window_q);
            check_field("pending_now", exp_beat.pending_now, rsp_pending_now);
            check_field("ok_total", exp_beat.ok_total, rsp_ok_total);
            check_field("late_total", exp_beat.late_total, rsp_late_total);
         end
      end
   end

   initial begin
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_valid     = 1'b0;
      req_action    = ACTION_ISSUE;
      req_now_ms    = '0;
      req_sent_ms   = '0;
      rsp_stall     = 1'b0;
      send_idle     = 1'b1;
      rsp_idle      = 1'b1;
      long_hold_req = 1'b0;
      rsp_hold_left = 0;
      n_errors      = 0;
      n_sent        = 0;
      n_checked     = 0;
      n_grants      = 0;
      n_backoffs    = 0;
      n_frac_steps  = 0;
      reset_throttle_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_events();
      test_zero_window();
      test_register_sweep();
      test_result_backpressure();
      test_window_full();
      wait_drained();

      $display("Ran %0d events and checked %0d result beats: %0d grants, %0d backoffs,",
               n_sent, n_checked, n_grants, n_backoffs);
      $display("%0d fractional growth steps, register extremes, zero window, full window",
               n_frac_steps);
      if (n_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
